### hdl/cct_pkg.sv
// Shared widths and pipeline word types for the circle collision time unit.
package cct_pkg;

    // Raw Q16.16 field width and the width of a difference of two fields
    localparam int PW   = 32;
    localparam int DW   = PW + 1;
    // Operand width for the quadratic coefficients and their halves
    localparam int OW   = 68;
    localparam int HALF = OW / 2;
    // Full product width and discriminant width
    localparam int PPW  = 2 * OW;
    localparam int DWID = PPW;
    // Square root result and partial remainder widths
    localparam int SW   = DWID / 2;
    localparam int RMW  = SW + 2;
    // Root numerator, division remainder and quotient widths
    localparam int NW   = SW + 2;
    localparam int QW   = 32;
    localparam int FRAC = 16;
    localparam int RW   = OW + QW - 2;

    // Control that travels with each word
    typedef struct packed {
        logic valid;
        logic live;
    } ctl_t;

    // Coefficients needed after the discriminant
    typedef struct packed {
        logic signed [OW-1:0] h;
        logic        [OW-1:0] a;
    } coef_t;

endpackage

### hdl/cct_front.sv
// Coefficient and discriminant stages: differences, products, A/H/C, D = H*H - A*C.
module cct_front
    import cct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [PW-1:0] first_pos_x,
    input  logic signed [PW-1:0] first_pos_y,
    input  logic signed [PW-1:0] first_vel_x,
    input  logic signed [PW-1:0] first_vel_y,
    input  logic        [PW-2:0] first_radius,
    input  logic signed [PW-1:0] second_pos_x,
    input  logic signed [PW-1:0] second_pos_y,
    input  logic signed [PW-1:0] second_vel_x,
    input  logic signed [PW-1:0] second_vel_y,
    input  logic        [PW-2:0] second_radius,
    output ctl_t                 ctl,
    output coef_t                coef,
    output logic      [DWID-1:0] disc
);

    // Stage 1: differences
    ctl_t                 s1_ctl_reg, s1_ctl_next;
    logic signed [DW-1:0] dxx_reg, dxy_reg, dvx_reg, dvy_reg;
    logic signed [DW-1:0] dxx_next, dxy_next, dvx_next, dvy_next;
    logic        [PW-1:0] rs_reg, rs_next;

    // Stage 2: products
    ctl_t                     s2_ctl_reg;
    logic signed [2*DW-1:0]   vxx_reg, vyy_reg, vxdx_reg, vydy_reg, xx_reg, yy_reg;
    logic        [2*PW-1:0]   rr_reg;

    // Stage 3: coefficients
    ctl_t                 s3_ctl_reg;
    logic        [OW-1:0] a3_reg, a3_next;
    logic signed [OW-1:0] h3_reg, h3_next, c3_reg, c3_next;

    // Stage 4: magnitudes
    ctl_t           s4_ctl_reg;
    coef_t          s4_coef_reg;
    logic [OW-1:0]  habs_reg, habs_next, cabs_reg, cabs_next;
    logic           cneg4_reg;

    // Stage 5: partial products
    ctl_t              s5_ctl_reg;
    coef_t             s5_coef_reg;
    logic              cneg5_reg;
    logic [2*HALF-1:0] p_hh_reg, p_hl_reg, p_ll_reg;
    logic [2*HALF-1:0] p_ahch_reg, p_ahcl_reg, p_alch_reg, p_alcl_reg;

    // Stage 6: full products
    ctl_t            s6_ctl_reg;
    coef_t           s6_coef_reg;
    logic            cneg6_reg;
    logic [PPW-1:0]  h2_reg, h2_next, ac_reg, ac_next;

    // Stage 7: discriminant
    ctl_t            s7_ctl_reg, s7_ctl_next;
    coef_t           s7_coef_reg;
    logic [DWID-1:0] disc_reg;
    logic [DWID:0]   dsum;

    // Stage 1 logic
    always_comb
    begin
        dxx_next = $signed({first_pos_x[PW-1], first_pos_x})
                 - $signed({second_pos_x[PW-1], second_pos_x});
        dxy_next = $signed({first_pos_y[PW-1], first_pos_y})
                 - $signed({second_pos_y[PW-1], second_pos_y});
        dvx_next = $signed({first_vel_x[PW-1], first_vel_x})
                 - $signed({second_vel_x[PW-1], second_vel_x});
        dvy_next = $signed({first_vel_y[PW-1], first_vel_y})
                 - $signed({second_vel_y[PW-1], second_vel_y});
        rs_next  = {1'b0, first_radius} + {1'b0, second_radius};
        s1_ctl_next.valid = in_valid;
        // zero relative velocity never hits
        s1_ctl_next.live  = (dvx_next != '0) || (dvy_next != '0);
    end

    // Stage 3 logic
    always_comb
    begin
        a3_next = OW'(vxx_reg) + OW'(vyy_reg);
        h3_next = OW'(vxdx_reg) + OW'(vydy_reg);
        c3_next = OW'(xx_reg) + OW'(yy_reg) - $signed(OW'(rr_reg));
    end

    // Stage 4 logic
    always_comb
    begin
        habs_next = h3_reg[OW-1] ? OW'(-h3_reg) : OW'(h3_reg);
        cabs_next = c3_reg[OW-1] ? OW'(-c3_reg) : OW'(c3_reg);
    end

    // Stage 6 logic: sum shifted partials
    always_comb
    begin
        h2_next = {p_hh_reg, {OW{1'b0}}}
                + (PPW'(p_hl_reg) << (HALF + 1))
                + PPW'(p_ll_reg);
        ac_next = {p_ahch_reg, {OW{1'b0}}}
                + (PPW'(p_ahcl_reg) << HALF)
                + (PPW'(p_alch_reg) << HALF)
                + PPW'(p_alcl_reg);
    end

    // Stage 7 logic: negative discriminant drops the hit
    always_comb
    begin
        dsum = cneg6_reg ? ({1'b0, h2_reg} + {1'b0, ac_reg})
                         : ({1'b0, h2_reg} - {1'b0, ac_reg});
        s7_ctl_next.valid = s6_ctl_reg.valid;
        s7_ctl_next.live  = s6_ctl_reg.live && !dsum[DWID];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
            s5_ctl_reg <= '0;
            s6_ctl_reg <= '0;
            s7_ctl_reg <= '0;
        end
        else if (en)
        begin
            s1_ctl_reg <= s1_ctl_next;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s3_ctl_reg;
            s5_ctl_reg <= s4_ctl_reg;
            s6_ctl_reg <= s5_ctl_reg;
            s7_ctl_reg <= s7_ctl_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxx_reg  <= dxx_next;
            dxy_reg  <= dxy_next;
            dvx_reg  <= dvx_next;
            dvy_reg  <= dvy_next;
            rs_reg   <= rs_next;

            vxx_reg  <= dvx_reg * dvx_reg;
            vyy_reg  <= dvy_reg * dvy_reg;
            vxdx_reg <= dvx_reg * dxx_reg;
            vydy_reg <= dvy_reg * dxy_reg;
            xx_reg   <= dxx_reg * dxx_reg;
            yy_reg   <= dxy_reg * dxy_reg;
            rr_reg   <= rs_reg * rs_reg;

            a3_reg   <= a3_next;
            h3_reg   <= h3_next;
            c3_reg   <= c3_next;

            s4_coef_reg.a <= a3_reg;
            s4_coef_reg.h <= h3_reg;
            habs_reg      <= habs_next;
            cabs_reg      <= cabs_next;
            cneg4_reg     <= c3_reg[OW-1];

            s5_coef_reg <= s4_coef_reg;
            cneg5_reg   <= cneg4_reg;
            p_hh_reg    <= habs_reg[OW-1:HALF] * habs_reg[OW-1:HALF];
            p_hl_reg    <= habs_reg[OW-1:HALF] * habs_reg[HALF-1:0];
            p_ll_reg    <= habs_reg[HALF-1:0] * habs_reg[HALF-1:0];
            p_ahch_reg  <= s4_coef_reg.a[OW-1:HALF] * cabs_reg[OW-1:HALF];
            p_ahcl_reg  <= s4_coef_reg.a[OW-1:HALF] * cabs_reg[HALF-1:0];
            p_alch_reg  <= s4_coef_reg.a[HALF-1:0] * cabs_reg[OW-1:HALF];
            p_alcl_reg  <= s4_coef_reg.a[HALF-1:0] * cabs_reg[HALF-1:0];

            s6_coef_reg <= s5_coef_reg;
            cneg6_reg   <= cneg5_reg;
            h2_reg      <= h2_next;
            ac_reg      <= ac_next;

            s7_coef_reg <= s6_coef_reg;
            disc_reg    <= dsum[DWID-1:0];
        end
    end

    assign ctl  = s7_ctl_reg;
    assign coef = s7_coef_reg;
    assign disc = disc_reg;

endmodule

### hdl/cct_sqrt_step.sv
// One digit stage of the integer square root: two radicand bits in, one root bit out.
module cct_sqrt_step
    import cct_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  ctl_t            ctl_in,
    input  coef_t           coef_in,
    input  logic [SW-1:0]   root_in,
    input  logic [RMW-1:0]  rem_in,
    input  logic [DWID-1:0] rad_in,
    output ctl_t            ctl_out,
    output coef_t           coef_out,
    output logic [SW-1:0]   root_out,
    output logic [RMW-1:0]  rem_out,
    output logic [DWID-1:0] rad_out
);

    ctl_t            ctl_reg;
    coef_t           coef_reg;
    logic [SW-1:0]   root_reg, root_next;
    logic [RMW-1:0]  rem_reg, rem_next, rem_sh, trial;
    logic [DWID-1:0] rad_reg, rad_next;
    logic            fits;

    // Trial subtract of 4*root + 1
    always_comb
    begin
        rem_sh    = {rem_in[RMW-3:0], rad_in[DWID-1 -: 2]};
        trial     = {root_in, 2'b01};
        fits      = rem_sh >= trial;
        rem_next  = fits ? (rem_sh - trial) : rem_sh;
        root_next = {root_in[SW-2:0], fits};
        rad_next  = {rad_in[DWID-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coef_reg <= coef_in;
            root_reg <= root_next;
            rem_reg  <= rem_next;
            rad_reg  <= rad_next;
        end
    end

    assign ctl_out  = ctl_reg;
    assign coef_out = coef_reg;
    assign root_out = root_reg;
    assign rem_out  = rem_reg;
    assign rad_out  = rad_reg;

endmodule

### hdl/cct_div_step.sv
// One quotient bit of the restoring division of the scaled root by A.
module cct_div_step
    import cct_pkg::*;
#(
    parameter int unsigned SHIFT = 0
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  ctl_t           ctl_in,
    input  logic [OW-1:0]  a_in,
    input  logic           sat_in,
    input  logic [RW-1:0]  rem_in,
    input  logic [QW-1:0]  q_in,
    output ctl_t           ctl_out,
    output logic [OW-1:0]  a_out,
    output logic           sat_out,
    output logic [RW-1:0]  rem_out,
    output logic [QW-1:0]  q_out
);

    ctl_t          ctl_reg;
    logic [OW-1:0] a_reg;
    logic          sat_reg;
    logic [RW-1:0] rem_reg, rem_next, sub;
    logic [QW-1:0] q_reg, q_next;
    logic          fits;

    // Compare against A shifted to this bit
    always_comb
    begin
        sub      = RW'(a_in) << SHIFT;
        fits     = rem_in >= sub;
        rem_next = fits ? (rem_in - sub) : rem_in;
        q_next   = q_in | (fits ? (QW'(1) << SHIFT) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= a_in;
            sat_reg <= sat_in;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign a_out   = a_reg;
    assign sat_out = sat_reg;
    assign rem_out = rem_reg;
    assign q_out   = q_reg;

endmodule

### hdl/circle_collision_time_unit.sv
// Throughput: one word per cycle while the output is not stalled; 7 coefficient stages,
// 68 square root digit stages, 2 root select stages, 32 division stages and the output
// register set the depth.
// A stalled output holds the whole pipeline; in_ready follows out_ready combinationally.
// Reset (rst_n low, asynchronous) clears every stage valid bit; datapath registers are not reset.
// Top level: moving circle time of impact, one result word per input word.
module circle_collision_time_unit
    import cct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [PW-1:0] first_pos_x,
    input  logic signed [PW-1:0] first_pos_y,
    input  logic signed [PW-1:0] first_vel_x,
    input  logic signed [PW-1:0] first_vel_y,
    input  logic        [PW-2:0] first_radius,
    input  logic signed [PW-1:0] second_pos_x,
    input  logic signed [PW-1:0] second_pos_y,
    input  logic signed [PW-1:0] second_vel_x,
    input  logic signed [PW-1:0] second_vel_y,
    input  logic        [PW-2:0] second_radius,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic        [QW-1:0] impact_time
);

    logic en;

    // Square root chain
    ctl_t            sq_ctl  [0:SW];
    coef_t           sq_coef [0:SW];
    logic [SW-1:0]   sq_root [0:SW];
    logic [RMW-1:0]  sq_rem  [0:SW];
    logic [DWID-1:0] sq_rad  [0:SW];

    // Root select stage
    ctl_t                 sel_ctl_reg, sel_ctl_next;
    logic        [OW-1:0] sel_a_reg;
    logic        [NW-1:0] sel_n_reg;
    logic signed [NW-1:0] hx, sx, n1, n2, n_pick;

    // Division setup stage
    ctl_t          prep_ctl_reg;
    logic [OW-1:0] prep_a_reg;
    logic          prep_sat_reg, prep_sat_next;
    logic [RW-1:0] prep_rem_reg, prep_rem_next;

    // Division chain
    ctl_t          dv_ctl [0:QW];
    logic [OW-1:0] dv_a   [0:QW];
    logic          dv_sat [0:QW];
    logic [RW-1:0] dv_rem [0:QW];
    logic [QW-1:0] dv_q   [0:QW];

    // Output register
    ctl_t          out_ctl_reg;
    logic          hit_reg, hit_next;
    logic [QW-1:0] time_reg, time_next;

    // Whole pipeline advances unless the output word is held
    assign en       = !out_ctl_reg.valid || out_ready;
    assign in_ready = en;

    cct_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (in_valid),
        .first_pos_x   (first_pos_x),
        .first_pos_y   (first_pos_y),
        .first_vel_x   (first_vel_x),
        .first_vel_y   (first_vel_y),
        .first_radius  (first_radius),
        .second_pos_x  (second_pos_x),
        .second_pos_y  (second_pos_y),
        .second_vel_x  (second_vel_x),
        .second_vel_y  (second_vel_y),
        .second_radius (second_radius),
        .ctl           (sq_ctl[0]),
        .coef          (sq_coef[0]),
        .disc          (sq_rad[0])
    );

    assign sq_root[0] = '0;
    assign sq_rem[0]  = '0;

    // Square root digit stages
    for (genvar i = 0; i < SW; i++)
    begin : g_sqrt
        cct_sqrt_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctl_in   (sq_ctl[i]),
            .coef_in  (sq_coef[i]),
            .root_in  (sq_root[i]),
            .rem_in   (sq_rem[i]),
            .rad_in   (sq_rad[i]),
            .ctl_out  (sq_ctl[i+1]),
            .coef_out (sq_coef[i+1]),
            .root_out (sq_root[i+1]),
            .rem_out  (sq_rem[i+1]),
            .rad_out  (sq_rad[i+1])
        );
    end

    // Pick the smaller non-negative root numerator
    always_comb
    begin
        hx     = NW'(sq_coef[SW].h);
        sx     = $signed(NW'(sq_root[SW]));
        n1     = -hx - sx;
        n2     = -hx + sx;
        n_pick = n1[NW-1] ? n2 : n1;
        sel_ctl_next.valid = sq_ctl[SW].valid;
        sel_ctl_next.live  = sq_ctl[SW].live && !n_pick[NW-1];
    end

    // Scale numerator and test for saturation
    always_comb
    begin
        prep_rem_next = RW'(sel_n_reg) << FRAC;
        prep_sat_next = RW'(sel_n_reg) >= (RW'(sel_a_reg) << FRAC);
    end

    assign dv_ctl[0] = prep_ctl_reg;
    assign dv_a[0]   = prep_a_reg;
    assign dv_sat[0] = prep_sat_reg;
    assign dv_rem[0] = prep_rem_reg;
    assign dv_q[0]   = '0;

    // Division stages, most significant quotient bit first
    for (genvar j = 0; j < QW; j++)
    begin : g_div
        cct_div_step #(
            .SHIFT (QW - 1 - j)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (dv_ctl[j]),
            .a_in    (dv_a[j]),
            .sat_in  (dv_sat[j]),
            .rem_in  (dv_rem[j]),
            .q_in    (dv_q[j]),
            .ctl_out (dv_ctl[j+1]),
            .a_out   (dv_a[j+1]),
            .sat_out (dv_sat[j+1]),
            .rem_out (dv_rem[j+1]),
            .q_out   (dv_q[j+1])
        );
    end

    // Final word: time is zero without a hit
    always_comb
    begin
        hit_next  = dv_ctl[QW].live;
        time_next = !dv_ctl[QW].live ? '0 : (dv_sat[QW] ? '1 : dv_q[QW]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_ctl_reg  <= '0;
            prep_ctl_reg <= '0;
            out_ctl_reg  <= '0;
        end
        else if (en)
        begin
            sel_ctl_reg  <= sel_ctl_next;
            prep_ctl_reg <= sel_ctl_reg;
            out_ctl_reg  <= dv_ctl[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_a_reg    <= sq_coef[SW].a;
            sel_n_reg    <= n_pick;
            prep_a_reg   <= sel_a_reg;
            prep_sat_reg <= prep_sat_next;
            prep_rem_reg <= prep_rem_next;
            hit_reg      <= hit_next;
            time_reg     <= time_next;
        end
    end

    assign out_valid   = out_ctl_reg.valid;
    assign hit         = hit_reg;
    assign impact_time = time_reg;

`ifndef NO_ASSERTIONS
    // A word without a hit carries a zero time
    a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> impact_time == '0)
        else $error("no-hit word with nonzero time");

    // Input side is held exactly when the output word is held
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not track the output stall");

    // Nothing comes out when reset is released
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output word present right after reset");
`endif

endmodule
